### rtl/lbr_pkg.sv
// Shared types, constants and helpers for the Bresenham line rasterizer.
package lbr_pkg;

  // Default coordinate width and command queue depth
  localparam int COORD_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration port shape and register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_W = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_H = 1'd1;

  // Surface size after reset
  localparam logic [CFG_DATA_W-1:0] SURF_W_RST = 13'd320;
  localparam logic [CFG_DATA_W-1:0] SURF_H_RST = 13'd200;

  // Input word modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Stepper status
  typedef struct packed {
    logic active;
    logic pop_start;
    logic emit;
    logic emit_last;
  } bk_stat_t;

  // Rotate RGBA to ARGB: alpha byte moves to the top
  function automatic logic [31:0] rgba_to_argb(input logic [31:0] c);
    rgba_to_argb = {c[7:0], c[31:8]};
  endfunction

endpackage

### rtl/lbr_front.sv
// Front end: accepts input words, classifies them and precomputes line setup.
module lbr_front #(
  parameter int COORD_BITS = lbr_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W    = 6 * COORD_BITS + 35
) (
  input  logic                in_valid_i,
  input  lbr_pkg::q_stat_t    q_stat_i,
  input  logic                mode_i,
  input  logic signed [15:0]  start_x_i,
  input  logic signed [15:0]  start_y_i,
  input  logic signed [15:0]  finish_x_i,
  input  logic signed [15:0]  finish_y_i,
  input  logic        [31:0]  color_rgba_i,
  output logic                push_o,
  output logic [ENTRY_W-1:0]  entry_o
);

  localparam int CW = COORD_BITS;

  logic                is_start;
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic signed [CW:0]   diff_x, diff_y;
  logic        [CW-1:0] dx, dy;
  logic                sx, sy;

  // Take the low coordinate bits as signed values
  assign x1 = $signed(start_x_i[CW-1:0]);
  assign y1 = $signed(start_y_i[CW-1:0]);
  assign x2 = $signed(finish_x_i[CW-1:0]);
  assign y2 = $signed(finish_y_i[CW-1:0]);

  // Signed spans, one bit wider so they never wrap
  assign diff_x = $signed({x2[CW-1], x2}) - $signed({x1[CW-1], x1});
  assign diff_y = $signed({y2[CW-1], y2}) - $signed({y1[CW-1], y1});

  // Magnitudes and step directions (step down unless start is below end)
  always_comb begin
    dx = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
    dy = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
    sx = diff_x[CW] || (diff_x == '0);
    sy = diff_y[CW] || (diff_y == '0);
  end

  assign is_start = (mode_i == lbr_pkg::MODE_START);

  // Push every accepted word into the queue
  assign push_o  = in_valid_i && !q_stat_i.full;
  assign entry_o = {is_start, x1, y1, x2, y2, dx, dy, sx, sy, color_rgba_i};

endmodule

### rtl/lbr_fifo.sv
// Short command queue between the front end and the stepper.
module lbr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lbr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  rdata_o,
  output lbr_pkg::q_stat_t  stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[rd_ptr_q];

endmodule

### rtl/lbr_back.sv
// Stepper: holds the active line, runs the error rule and drives the output register.
module lbr_back #(
  parameter int COORD_BITS = lbr_pkg::COORD_BITS_DEF,
  parameter int ENTRY_W    = 6 * COORD_BITS + 35
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lbr_pkg::q_stat_t                   q_stat_i,
  input  logic [ENTRY_W-1:0]                 head_i,
  output logic                               pop_o,
  input  logic [lbr_pkg::CFG_DATA_W-1:0]     surf_w_i,
  input  logic [lbr_pkg::CFG_DATA_W-1:0]     surf_h_i,
  output lbr_pkg::bk_stat_t                  stat_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [15:0]                 pixel_x_o,
  output logic signed [15:0]                 pixel_y_o,
  output logic                               inside_res_o,
  output logic        [31:0]                 pixel_argb_o,
  output logic                               last_o
);

  localparam int CW  = COORD_BITS;
  localparam int EW  = CW + 2;
  localparam int E2W = CW + 3;
  localparam int XW  = 17;

  // Unpacked queue head
  logic                 h_start;
  logic signed [CW-1:0] h_x1, h_y1, h_x2, h_y2;
  logic        [CW-1:0] h_dx, h_dy;
  logic                 h_sx, h_sy;
  logic        [31:0]   h_color;

  assign {h_start, h_x1, h_y1, h_x2, h_y2, h_dx, h_dy, h_sx, h_sy, h_color} = head_i;

  // Line state
  logic signed [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CW-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic        [CW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [EW-1:0] err_q, err_d;
  logic                 sx_q, sx_d, sy_q, sy_d;
  logic        [31:0]   color_q, color_d;
  logic                 active_q, active_d;
  logic                 out_valid_q, out_valid_d;

  // Output payload
  logic signed [15:0]   px_q, px_d, py_q, py_d;
  logic                 inside_q, inside_d;
  logic        [31:0]   argb_q, argb_d;
  logic                 last_q, last_d;

  logic                 can_load, pop, emit, at_end, step_x, step_y;
  logic signed [E2W-1:0] e2, err_ext, err_next;
  logic signed [XW-1:0]  xe, ye;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    err_d    = err_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    color_d  = color_q;
    active_d = active_q;
    out_valid_d = out_valid_q;

    // Pop one word whenever the output register can take a result
    can_load = !out_valid_q || !out_stall_i;
    pop      = !q_stat_i.empty && can_load;
    emit     = pop && !h_start && active_q;
    at_end   = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

    // Error rule on the doubled error term
    e2       = $signed({err_q, 1'b0});
    err_ext  = E2W'(err_q);
    step_x   = e2 > -$signed({3'b000, dy_q});
    step_y   = e2 < $signed({3'b000, dx_q});
    err_next = err_ext - (step_x ? $signed({3'b000, dy_q}) : '0)
                       + (step_y ? $signed({3'b000, dx_q}) : '0);

    // Clip test against the surface
    xe       = XW'(cur_x_q);
    ye       = XW'(cur_y_q);
    inside_d = !cur_x_q[CW-1] && (xe < $signed({4'b0000, surf_w_i})) &&
               !cur_y_q[CW-1] && (ye < $signed({4'b0000, surf_h_i}));
    px_d     = 16'(cur_x_q);
    py_d     = 16'(cur_y_q);
    argb_d   = lbr_pkg::rgba_to_argb(color_q);
    last_d   = at_end;

    if (pop && h_start) begin
      // Load a new line, replacing any active one
      cur_x_d  = h_x1;
      cur_y_d  = h_y1;
      tgt_x_d  = h_x2;
      tgt_y_d  = h_y2;
      dx_d     = h_dx;
      dy_d     = h_dy;
      err_d    = $signed({2'b00, h_dx}) - $signed({2'b00, h_dy});
      sx_d     = h_sx;
      sy_d     = h_sy;
      color_d  = h_color;
      active_d = 1'b1;
    end else if (emit) begin
      if (at_end) begin
        active_d = 1'b0;
      end else begin
        err_d = err_next[EW-1:0];
        if (step_x) begin
          cur_x_d = sx_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
        end
        if (step_y) begin
          cur_y_d = sy_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
        end
      end
    end

    // Output register: refill when free or taken
    if (can_load) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      err_q       <= '0;
      sx_q        <= 1'b0;
      sy_q        <= 1'b0;
      color_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      err_q       <= err_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      color_q     <= color_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result payload only on emit
  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q     <= px_d;
      py_q     <= py_d;
      inside_q <= inside_d;
      argb_q   <= argb_d;
      last_q   <= last_d;
    end
  end

  assign pop_o        = pop;
  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign inside_res_o = inside_q;
  assign pixel_argb_o = argb_q;
  assign last_o       = last_q;

  assign stat_o.active    = active_q;
  assign stat_o.pop_start = pop && h_start;
  assign stat_o.emit      = emit;
  assign stat_o.emit_last = emit && at_end;

endmodule

### rtl/bresenham_line_raster.sv
// Top level of the Bresenham line rasterizer: config registers, front end, queue, stepper.
//
//  channel  | handshake              | word
//  ---------+------------------------+------------------------------------------------
//  input    | in_valid_i / in_stall_o | mode, start/finish x/y, color_rgba
//  output   | out_valid_o / out_stall_i | pixel_x/y, inside_res, pixel_argb, last
//  config   | cfg_we_i               | cfg_idx_i selects register, cfg_wdata_i data
//
// One word is accepted per cycle while the command queue has room; the stepper
// pops one word per cycle while the output is not stalled, so one pixel leaves per
// cycle at full rate. A step word is written into the queue, popped by the stepper
// and then held in the output register; words queued ahead of it are popped first.
// The stepper's error update, made once per step word, sets the rate; the queue holds
// QUEUE_DEPTH words so each side can stall on its own.
// Reset clears the queue, the line state (no line active) and sets the surface to 320x200.
module bresenham_line_raster #(
  parameter int COORD_BITS  = lbr_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = lbr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lbr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lbr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic signed [15:0]                start_x_i,
  input  logic signed [15:0]                start_y_i,
  input  logic signed [15:0]                finish_x_i,
  input  logic signed [15:0]                finish_y_i,
  input  logic        [31:0]                color_rgba_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                pixel_x_o,
  output logic signed [15:0]                pixel_y_o,
  output logic                              inside_res_o,
  output logic        [31:0]                pixel_argb_o,
  output logic                              last_o
);

  localparam int ENTRY_W = 6 * COORD_BITS + 35;

  logic [lbr_pkg::CFG_DATA_W-1:0] surf_w_q, surf_h_q;
  lbr_pkg::q_stat_t               q_stat;
  lbr_pkg::bk_stat_t              bk_stat;
  logic                           q_push, q_pop;
  logic [ENTRY_W-1:0]             q_wdata, q_rdata;

  // Surface size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_w_q <= lbr_pkg::SURF_W_RST;
      surf_h_q <= lbr_pkg::SURF_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbr_pkg::REG_SURF_W: surf_w_q <= cfg_wdata_i;
        lbr_pkg::REG_SURF_H: surf_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_stat.full;

  lbr_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .q_stat_i     (q_stat),
    .mode_i       (mode_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .finish_x_i   (finish_x_i),
    .finish_y_i   (finish_y_i),
    .color_rgba_i (color_rgba_i),
    .push_o       (q_push),
    .entry_o      (q_wdata)
  );

  lbr_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  lbr_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .head_i       (q_rdata),
    .pop_o        (q_pop),
    .surf_w_i     (surf_w_q),
    .surf_h_i     (surf_h_q),
    .stat_o       (bk_stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .inside_res_o (inside_res_o),
    .pixel_argb_o (pixel_argb_o),
    .last_o       (last_o)
  );

  // Queue is never both full and empty
  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // An accepted word leaves the queue non-empty
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_stat.empty)
    else $error("accepted word lost from queue");

  // An emitted pixel shows up on the output
  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.emit |=> out_valid_o)
    else $error("emitted pixel not presented");

  // A start word activates the line
  a_start_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop_start |=> bk_stat.active)
    else $error("start word did not activate line");

  // The end point ends the line
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.emit_last |=> !bk_stat.active)
    else $error("line still active after end point");

endmodule
